>>> src/brmr_pkg.sv
// shared constants for the broadcast ring with several readers
// operation and status codes, field widths and parameter defaults
// no dependencies
package brmr_pkg;

    localparam int WORD_W = 32;
    localparam int CNT_W  = 32;
    localparam int OP_W   = 2;
    localparam int RDR_W  = 2;
    localparam int ST_W   = 3;

    // readers addressable through the reader field
    localparam int RDR_FIELD_SLOTS = 1 << RDR_W;

    localparam int DEPTH_DEF       = 1024;
    localparam int NUM_READERS_DEF = 4;
    localparam int DATA_WIDTH_DEF  = 32;

    localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
    localparam logic [OP_W-1:0] OP_READ   = 2'd1;
    localparam logic [OP_W-1:0] OP_ATTACH = 2'd2;

    localparam logic [ST_W-1:0] ST_WRITTEN  = 3'd0;
    localparam logic [ST_W-1:0] ST_DATA     = 3'd1;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [ST_W-1:0] ST_OVERRUN  = 3'd3;
    localparam logic [ST_W-1:0] ST_ATTACHED = 3'd4;

endpackage

>>> src/brmr_ring_mem.sv
// ring storage: one write port and one read port, registered read data
// uses no package items
module brmr_ring_mem #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32,
    parameter int AW         = 10
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  logic [DATA_WIDTH-1:0] wdata,
    input  logic                  re,
    input  logic [AW-1:0]         raddr,
    output logic [DATA_WIDTH-1:0] rdata
);

    logic [DATA_WIDTH-1:0] ring_mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ring_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= ring_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/brmr_ctrl.sv
// write count, reader counts and slot pointers, op decode and output stage
// depends on brmr_pkg; drives the ring memory ports
module brmr_ctrl
    import brmr_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int NUM_READERS = NUM_READERS_DEF,
    parameter int AW          = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [OP_W-1:0]   op,
    input  logic [RDR_W-1:0]  reader,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [ST_W-1:0]   status,
    output logic              mem_we,
    output logic [AW-1:0]     mem_waddr,
    output logic              mem_re,
    output logic [AW-1:0]     mem_raddr
);

    // readers beyond what the reader field can name are never touched
    localparam int NUM_SLOTS = (NUM_READERS < RDR_FIELD_SLOTS) ? NUM_READERS
                                                               : RDR_FIELD_SLOTS;
    localparam int RIDX_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic [CNT_W-1:0] wcount_reg, wcount_next;
    logic [AW-1:0]    wslot_reg, wslot_next;
    logic [CNT_W-1:0] rcount_reg [NUM_SLOTS];
    logic [CNT_W-1:0] rcount_next [NUM_SLOTS];
    logic [AW-1:0]    rslot_reg [NUM_SLOTS];
    logic [AW-1:0]    rslot_next [NUM_SLOTS];
    logic             out_valid_reg, out_valid_next;
    logic [ST_W-1:0]  status_reg, status_next;

    logic              in_accept;
    logic              out_accept;
    logic              in_range;
    logic [RIDX_W-1:0] idx;
    logic [CNT_W-1:0]  rcount_sel;
    logic [AW-1:0]     rslot_sel;
    logic [CNT_W-1:0]  pending;

    assign out_accept = out_valid_reg && !out_stall;
    assign in_stall   = out_valid_reg && out_stall;
    assign in_accept  = in_valid && !in_stall;

    assign in_range   = ({1'b0, reader} < (RDR_W + 1)'(NUM_SLOTS));
    assign idx        = RIDX_W'(reader);
    assign rcount_sel = in_range ? rcount_reg[idx] : '0;
    assign rslot_sel  = in_range ? rslot_reg[idx] : '0;
    assign pending    = wcount_reg - rcount_sel;

    assign mem_waddr = wslot_reg;
    assign mem_raddr = rslot_sel;

    always_comb
    begin
        wcount_next = wcount_reg;
        wslot_next  = wslot_reg;
        rcount_next = rcount_reg;
        rslot_next  = rslot_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        status_next = status_reg;
        if (in_accept)
        begin
            status_next = ST_EMPTY;
            case (op)
                OP_WRITE:
                begin
                    mem_we      = 1'b1;
                    wcount_next = wcount_reg + 1'b1;
                    // slot restarts at zero on depth wrap and on counter wrap
                    if ((&wcount_reg) || (wslot_reg == AW'(DEPTH - 1)))
                    begin
                        wslot_next = '0;
                    end
                    else
                    begin
                        wslot_next = wslot_reg + 1'b1;
                    end
                    status_next = ST_WRITTEN;
                end
                OP_READ:
                begin
                    if (in_range)
                    begin
                        if (pending == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else if (pending > CNT_W'(DEPTH))
                        begin
                            // writer lapped this reader: resync
                            rcount_next[idx] = wcount_reg;
                            rslot_next[idx]  = wslot_reg;
                            status_next      = ST_OVERRUN;
                        end
                        else
                        begin
                            mem_re           = 1'b1;
                            rcount_next[idx] = rcount_sel + 1'b1;
                            if ((&rcount_sel) || (rslot_sel == AW'(DEPTH - 1)))
                            begin
                                rslot_next[idx] = '0;
                            end
                            else
                            begin
                                rslot_next[idx] = rslot_sel + 1'b1;
                            end
                            status_next = ST_DATA;
                        end
                    end
                end
                OP_ATTACH:
                begin
                    if (in_range)
                    begin
                        rcount_next[idx] = wcount_reg;
                        rslot_next[idx]  = wslot_reg;
                    end
                    status_next = ST_ATTACHED;
                end
                default:
                begin
                    status_next = ST_EMPTY;
                end
            endcase
        end
    end

    always_comb
    begin
        if (in_accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_accept)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wcount_reg    <= '0;
            wslot_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                rcount_reg[i] <= '0;
                rslot_reg[i]  <= '0;
            end
        end
        else
        begin
            wcount_reg    <= wcount_next;
            wslot_reg     <= wslot_next;
            out_valid_reg <= out_valid_next;
            rcount_reg    <= rcount_next;
            rslot_reg     <= rslot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg)
        else $error("input stalled with an empty output stage");

    a_accept_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid_reg)
        else $error("accepted transfer produced no result");

    a_write_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && op == OP_WRITE) |=> wcount_reg == $past(wcount_reg) + 1'b1)
        else $error("write count did not advance on a write");

    a_one_mem_access: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({mem_we, mem_re}))
        else $error("ring read and write in the same cycle");

    a_data_read_issued: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && status_next == ST_DATA) |-> mem_re)
        else $error("data status without a ring read");

endmodule

>>> src/broadcast_ring_multi_reader.sv
// a result is registered and presented in the cycle after its input transfer
// throughput: one item per cycle while the output is not stalled; the ring
//   has a single read port with registered read data
// reset: write count, reader counts and output valid clear asynchronously;
//   ring contents are not cleared and no clearing pass runs
module broadcast_ring_multi_reader
    import brmr_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int NUM_READERS = NUM_READERS_DEF,
    parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [OP_W-1:0]   op,
    input  logic [RDR_W-1:0]  reader,
    input  logic [WORD_W-1:0] wr_data,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [ST_W-1:0]   status,
    output logic [WORD_W-1:0] rd_data
);

    localparam int AW = $clog2(DEPTH);

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [DATA_WIDTH-1:0] mem_rdata;

    assign mem_wdata = DATA_WIDTH'(wr_data);

    brmr_ctrl #(
        .DEPTH       (DEPTH),
        .NUM_READERS (NUM_READERS),
        .AW          (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .reader    (reader),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr)
    );

    brmr_ring_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW)
    ) u_ring (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // read data carries the ring word when the status is data, and is zero otherwise
    assign rd_data = (status == ST_DATA) ? WORD_W'(mem_rdata) : '0;

endmodule
